FILE: rtl/gec_pkg.sv
// ----------------------------------------------------------------------------
// Greedy element coloring package
// Shared field widths, command and status bundles and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package gec_pkg;

  localparam int DOF_W       = 12;
  localparam int DOF_SPAN    = 2 ** DOF_W;
  localparam int ELEM_W      = 16;
  localparam int COLOR_OUT_W = 5;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 24;
  localparam int M_PAD_W     = M_TDATA_W - ELEM_W - COLOR_OUT_W;
  localparam int M_TUSER_W   = 2;
  localparam int COLOR_LSB   = ELEM_W;
  localparam int USER_NO_FREE = 0;
  localparam int USER_OVF     = 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_READ,
    ST_GATHER,
    ST_PICK,
    ST_WB
  } gec_state_t;

  typedef struct packed {
    logic clear_en;
    logic load_in;
    logic red_step;
    logic gather_issue;
    logic gather_or;
    logic pick;
  } gec_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic red_done;
    logic last;
    logic out_free;
    logic wb_idle;
  } gec_status_t;

endpackage

`default_nettype wire

FILE: rtl/gec_ctrl.sv
// ----------------------------------------------------------------------------
// Greedy element coloring controller
// Sequences the clearing pass, index reduction, dof gathering, color pick and write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module gec_ctrl import gec_pkg::*; #(
  parameter bit DIRECT_ADDR = 1'b1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  gec_status_t st,
  output gec_cmd_t    cmd
);

  gec_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (st.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = DIRECT_ADDR ? ST_GATHER : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (st.red_done) begin
          state_next = ST_READ;
        end else begin
          cmd.red_step = 1'b1;
        end
      end
      ST_READ: begin
        cmd.gather_issue = 1'b1;
        state_next       = ST_GATHER;
      end
      ST_GATHER: begin
        cmd.gather_or = 1'b1;
        state_next    = st.last ? ST_PICK : ST_IDLE;
      end
      ST_PICK: begin
        if (st.out_free) begin
          cmd.pick   = 1'b1;
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        if (st.wb_idle) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/gec_datapath.sv
// ----------------------------------------------------------------------------
// Greedy element coloring datapath
// Used-color memory, element dof buffer, index reduction, color pick,
// write-back pipeline and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gec_datapath import gec_pkg::*; #(
  parameter int MAX_DOFS   = 4096,
  parameter int MAX_COLORS = 32,
  parameter int MAX_LOCAL  = 32,
  parameter int RED_STEPS  = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gec_cmd_t             cmd,
  output gec_status_t          st,
  input  logic [DOF_W-1:0]     dof_index,
  input  logic                 last_in,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [M_TUSER_W-1:0] m_tuser
);

  localparam int MEM_DEPTH = (MAX_DOFS < DOF_SPAN) ? MAX_DOFS : DOF_SPAN;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CNT_W     = $clog2(MAX_LOCAL + 1);
  localparam int LIDX_W    = (MAX_LOCAL > 1) ? $clog2(MAX_LOCAL) : 1;
  localparam int RC_W      = (RED_STEPS > 0) ? $clog2(RED_STEPS + 1) : 1;
  localparam logic [DOF_W:0] DIV_BASE = (DOF_W + 1)'(MAX_DOFS);

  logic [MAX_COLORS-1:0] mem [MEM_DEPTH];
  logic [MAX_COLORS-1:0] mem_q;
  logic [ADDR_W-1:0]     buf_mem [MAX_LOCAL];
  logic [ADDR_W-1:0]     buf_q;

  logic [DOF_W-1:0]      rem;
  logic [RC_W-1:0]       red_cnt;
  logic                  last;
  logic [MAX_COLORS-1:0] gathered;
  logic [CNT_W-1:0]      count;
  logic                  overflow;
  logic [ELEM_W-1:0]     elem_cnt;
  logic [ADDR_W-1:0]     clr_addr;
  logic [CNT_W-1:0]      wb_left;
  logic [LIDX_W-1:0]     wb_idx;
  logic                  wb_v1;
  logic                  wb_v2;
  logic [ADDR_W-1:0]     wb_addr;
  logic [MAX_COLORS-1:0] color_bit;

  logic                  issue;
  logic [ADDR_W-1:0]     issue_addr;
  logic                  room;
  logic [DOF_W:0]        red_div;
  logic                  red_ge;
  logic [MAX_COLORS-1:0] free;
  logic [MAX_COLORS-1:0] pick_onehot;
  logic                  found;
  logic [COLOR_OUT_W-1:0] pick_color;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [MAX_COLORS-1:0] wr_data;
  logic                  wb_issue;

  always_comb begin
    issue      = (cmd.load_in && (RED_STEPS == 0)) || cmd.gather_issue;
    issue_addr = cmd.gather_issue ? rem[ADDR_W-1:0] : dof_index[ADDR_W-1:0];
    room       = count < CNT_W'(MAX_LOCAL);
    red_div    = DIV_BASE << (red_cnt - RC_W'(1));
    red_ge     = {1'b0, rem} >= red_div;
    free        = ~gathered;
    pick_onehot = free & (~free + MAX_COLORS'(1));
    found       = |free;
    pick_color  = '0;
    for (int i = MAX_COLORS - 1; i >= 0; i--) begin
      if (free[i]) begin
        pick_color = COLOR_OUT_W'(i);
      end
    end
    wb_issue = wb_left != '0;
    rd_en    = issue || wb_v1;
    rd_addr  = wb_v1 ? buf_q : issue_addr;
    wr_en    = cmd.clear_en || wb_v2;
    wr_addr  = cmd.clear_en ? clr_addr : wb_addr;
    wr_data  = cmd.clear_en ? '0 : (mem_q | color_bit);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue && room) begin
      buf_mem[count[LIDX_W-1:0]] <= issue_addr;
    end
    if (wb_issue) begin
      buf_q <= buf_mem[wb_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_en) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red_cnt <= '0;
      last    <= 1'b0;
    end else if (cmd.load_in) begin
      red_cnt <= RC_W'(RED_STEPS);
      last    <= last_in;
    end else if (cmd.red_step) begin
      red_cnt <= red_cnt - RC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rem <= dof_index;
    end else if (cmd.red_step && red_ge) begin
      rem <= rem - red_div[DOF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.pick) begin
      gathered <= '0;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      if (cmd.gather_or) begin
        gathered <= gathered | mem_q;
      end
      if (issue) begin
        if (room) begin
          count <= count + CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_cnt <= '0;
    end else if (cmd.pick) begin
      elem_cnt <= elem_cnt + ELEM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_left <= '0;
      wb_idx  <= '0;
      wb_v1   <= 1'b0;
      wb_v2   <= 1'b0;
    end else begin
      if (cmd.pick) begin
        wb_left <= found ? count : '0;
        wb_idx  <= '0;
      end else if (wb_issue) begin
        wb_left <= wb_left - CNT_W'(1);
        wb_idx  <= wb_idx + LIDX_W'(1);
      end
      wb_v1 <= wb_issue;
      wb_v2 <= wb_v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      color_bit <= pick_onehot;
    end
    if (wb_v1) begin
      wb_addr <= buf_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.pick) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      m_tdata                <= {{M_PAD_W{1'b0}}, pick_color, elem_cnt};
      m_tuser[USER_NO_FREE]  <= ~found;
      m_tuser[USER_OVF]      <= overflow;
    end
  end

  always_comb begin
    st.clear_last = clr_addr == ADDR_W'(MEM_DEPTH - 1);
    st.red_done   = red_cnt == '0;
    st.last       = last;
    st.out_free   = !m_tvalid || m_tready;
    st.wb_idle    = (wb_left == '0) && !wb_v1 && !wb_v2;
  end

endmodule

`default_nettype wire

FILE: rtl/greedy_element_coloring.sv
// ----------------------------------------------------------------------------
// Greedy element coloring
// Colors mesh elements so that elements sharing a dof never share a color.
// ----------------------------------------------------------------------------
// Each dof is taken and then gathered directly when MAX_DOFS is a power of
// two or at least 4096; otherwise its index is first reduced by a subtract
// loop, then read and gathered. An element end adds a pick and a write-back
// of the buffered dofs (none with no free color); the result is shown in the cycle after the pick.
// After reset a clearing pass over min(MAX_DOFS, 4096) addresses zeroes the
// used-color memory while s_tready stays low.
`default_nettype none

module greedy_element_coloring import gec_pkg::*; #(
  parameter int MAX_DOFS   = 4096,
  parameter int MAX_COLORS = 32,
  parameter int MAX_LOCAL  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] dof_index, [15:12] zero
  input  logic                 s_tlast,   // last_of_element
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [15:0] element_number,
                                          // [20:16] assigned_color, [23:21] zero
  output logic [M_TUSER_W-1:0] m_tuser    // [0] no_free_color, [1] dof_overflow
);

  localparam bit DIRECT_ADDR = ((MAX_DOFS & (MAX_DOFS - 1)) == 0) || (MAX_DOFS >= DOF_SPAN);
  localparam int QUOT_MAX    = (DOF_SPAN + MAX_DOFS - 1) / MAX_DOFS;
  localparam int RED_STEPS   = DIRECT_ADDR ? 0 : $clog2(QUOT_MAX);

  gec_cmd_t    cmd;
  gec_status_t st;

  gec_ctrl #(
    .DIRECT_ADDR (DIRECT_ADDR)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  gec_datapath #(
    .MAX_DOFS   (MAX_DOFS),
    .MAX_COLORS (MAX_COLORS),
    .MAX_LOCAL  (MAX_LOCAL),
    .RED_STEPS  (RED_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .dof_index (s_tdata[DOF_W-1:0]),
    .last_in   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/gec_checker.sv
// ----------------------------------------------------------------------------
// Greedy element coloring port checker
// Watches the stream ports of the top level and flags illegal behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module gec_checker import gec_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [M_TUSER_W-1:0] m_tuser
);

  // A result is never shown right after reset, since the clearing pass runs first.
  a_no_result_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("result shown right after reset");

  // A stalled result holds its value.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // With no free color the color field reads zero.
  a_no_free_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_NO_FREE] |-> m_tdata[COLOR_LSB +: COLOR_OUT_W] == '0)
    else $error("color field not zero with no free color");

  // Each input transfer is worked on before the next is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while previous dof still in work");

endmodule

bind greedy_element_coloring gec_checker u_gec_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
